// ===== rtl/core/gqtu_pkg.sv =====
package gqtu_pkg;

  // Widths that the item and register fields fix
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned COORD_W    = 4;
  localparam int unsigned REWARD_W   = 16;
  localparam int unsigned OUT_W      = 32;
  // Grid compares: holds a dimension up to 255 and a 5-bit register plus one
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned NUM_MOVES  = 4;

  // Q1.16 unity
  localparam logic [CFG_DATA_W-1:0] ONE_Q16 = 17'd65536;
  localparam int unsigned           HALF_Q16 = 32768;

  localparam logic [4:0]            GRID_ROWS_RST  = 5'd4;
  localparam logic [4:0]            GRID_COLS_RST  = 5'd12;
  localparam logic [CFG_DATA_W-1:0] LEARN_RATE_RST = 17'd32768;
  localparam logic [CFG_DATA_W-1:0] DISCOUNT_RST   = 17'd58982;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS  = 2'd0,
    CFG_GRID_COLS  = 2'd1,
    CFG_LEARN_RATE = 2'd2,
    CFG_DISCOUNT   = 2'd3
  } gqtu_cfg_e;

  typedef enum logic [1:0] {
    MOVE_ROW_INC = 2'd0,
    MOVE_COL_INC = 2'd1,
    MOVE_ROW_DEC = 2'd2,
    MOVE_COL_DEC = 2'd3
  } gqtu_move_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_NEXT,
    S_CUR,
    S_TGT,
    S_MIX,
    S_WR
  } gqtu_state_e;

  typedef struct packed {
    logic [COORD_W-1:0]         cur_row;
    logic [COORD_W-1:0]         cur_col;
    logic [1:0]                 move;
    logic signed [REWARD_W-1:0] reward_in;
    logic [COORD_W-1:0]         next_row;
    logic [COORD_W-1:0]         next_col;
    logic [1:0]                 tie_pick;
  } gqtu_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] new_value;
    logic [1:0]              best_move;
    logic signed [OUT_W-1:0] best_value;
    logic                    bad_item;
  } gqtu_res_t;

endpackage

// ===== rtl/core/grid_q_table_update_top.sv =====
// Channel   Signals                                  Direction  Handshake
// request   start, busy, req_i                       in         start && !busy
// result    res_valid_o, res_o                       out        strobe, one cycle
// config    cfg_valid_i, cfg_ready_o, cfg_index_i,   in         valid && ready
//           cfg_data_i
//
// A good request passes these states before its result strobe: next-cell row
// read and max, current-cell row read with the gamma product, target, alpha blend,
// write-back. busy drops with the strobe, and the next request can be accepted in that
// cycle; the two reads through one table read port and the multiplier chain mean a
// new request is not taken before the last one is through.
// A rejected request returns its strobe in the cycle after acceptance.
// After reset the table is swept to zero, one cell row a cycle
// over all MAX_ROWS*MAX_COLS cell rows (256 by default) with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module grid_q_table_update_top #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  gqtu_pkg::gqtu_req_t                 req_i,
  output logic                                res_valid_o,
  output gqtu_pkg::gqtu_res_t                 res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gqtu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gqtu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import gqtu_pkg::*;

  // One table row per cell holds the four move entries, move 0 in the low bits
  localparam int Cells  = MAX_ROWS * MAX_COLS;
  localparam int AddrW  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int RowW   = NUM_MOVES * VALUE_BITS;
  localparam int ProdW  = VALUE_BITS + 18;
  localparam int WideW  = VALUE_BITS + 19;

  localparam logic signed [WideW-1:0] VMax = WideW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [WideW-1:0] VMin = -VMax - WideW'(1);
  localparam logic signed [WideW-1:0] Round = WideW'(HALF_Q16);

  function automatic logic signed [VALUE_BITS-1:0] sat_v(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] y;
    begin
      y = x;
      if (x > VMax) y = VMax;
      if (x < VMin) y = VMin;
      sat_v = y[VALUE_BITS-1:0];
    end
  endfunction

  // Does the move from (row, col) stay inside the grid in use
  function automatic logic step_ok(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                                   input logic [1:0] mv, input logic [DIM_W-1:0] rows,
                                   input logic [DIM_W-1:0] cols);
    logic ok;
    begin
      ok = 1'b0;
      unique case (mv)
        MOVE_ROW_INC: ok = (DIM_W'(row) + DIM_W'(1)) < rows;
        MOVE_COL_INC: ok = (DIM_W'(col) + DIM_W'(1)) < cols;
        MOVE_ROW_DEC: ok = row != '0;
        MOVE_COL_DEC: ok = col != '0;
        default:      ok = 1'b0;
      endcase
      step_ok = ok;
    end
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
    cell_addr = AddrW'(int'(row) * MAX_COLS + int'(col));
  endfunction

  // Configuration registers
  logic [4:0]            grid_rows_q, grid_cols_q;
  logic [CFG_DATA_W-1:0] learn_rate_q, discount_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= GRID_ROWS_RST;
      grid_cols_q  <= GRID_COLS_RST;
      learn_rate_q <= LEARN_RATE_RST;
      discount_q   <= DISCOUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gqtu_cfg_e'(cfg_index_i))
        CFG_GRID_ROWS:  grid_rows_q  <= cfg_data_i[4:0];
        CFG_GRID_COLS:  grid_cols_q  <= cfg_data_i[4:0];
        CFG_LEARN_RATE: learn_rate_q <= cfg_data_i;
        CFG_DISCOUNT:   discount_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective grid size and Q1.16 factors, clipped at their limits
  logic [DIM_W-1:0]      eff_rows, eff_cols;
  logic [CFG_DATA_W-1:0] alpha, gamma;

  assign eff_rows = (DIM_W'(grid_rows_q) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                            : DIM_W'(grid_rows_q);
  assign eff_cols = (DIM_W'(grid_cols_q) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                            : DIM_W'(grid_cols_q);
  assign alpha = (learn_rate_q > ONE_Q16) ? ONE_Q16 : learn_rate_q;
  assign gamma = (discount_q > ONE_Q16) ? ONE_Q16 : discount_q;

  // Request checks, taken straight off the request port
  logic                 accept;
  logic                 item_bad;
  logic [NUM_MOVES-1:0] next_moves;

  assign accept = start && !busy;

  always_comb begin
    item_bad = !((DIM_W'(req_i.cur_row) < eff_rows) && (DIM_W'(req_i.cur_col) < eff_cols) &&
                 (DIM_W'(req_i.next_row) < eff_rows) && (DIM_W'(req_i.next_col) < eff_cols) &&
                 step_ok(req_i.cur_row, req_i.cur_col, req_i.move, eff_rows, eff_cols));
    for (int a = 0; a < NUM_MOVES; a++) begin
      next_moves[a] = step_ok(req_i.next_row, req_i.next_col, 2'(a), eff_rows, eff_cols);
    end
  end

  // Table
  gqtu_state_e       state_q, state_d;
  logic [AddrW-1:0]  clr_q;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [RowW-1:0]   ram_wdata, ram_rdata;

  gqtu_ram #(
    .Width (RowW),
    .Depth (Cells)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Held request and datapath registers
  gqtu_req_t                     req_q;
  logic [NUM_MOVES-1:0]          moves_q;
  logic signed [VALUE_BITS-1:0]  best_q, old_q, target_q;
  logic [1:0]                    best_m_q;
  logic [RowW-1:0]               cur_row_q;
  logic signed [ProdW-1:0]       prod_g_q, p_old_q, p_tgt_q;

  // Max over the next cell's valid moves, ties resolved by tie_pick
  logic signed [VALUE_BITS-1:0] vals [NUM_MOVES];
  logic signed [VALUE_BITS-1:0] best_d;
  logic [1:0]                   best_m_d;
  logic [NUM_MOVES-1:0]         tied;
  logic [2:0]                   tie_cnt, seen;
  logic [1:0]                   rank;
  logic                         any, found;

  always_comb begin
    best_d   = '0;
    best_m_d = MOVE_ROW_INC;
    any      = 1'b0;
    found    = 1'b0;
    seen     = '0;
    rank     = '0;
    for (int a = 0; a < NUM_MOVES; a++) begin
      vals[a] = ram_rdata[a*VALUE_BITS +: VALUE_BITS];
      if (moves_q[a] && (!any || vals[a] > best_d)) begin
        best_d = vals[a];
      end
      any = any | moves_q[a];
    end
    for (int a = 0; a < NUM_MOVES; a++) begin
      tied[a] = moves_q[a] && (vals[a] == best_d);
    end
    tie_cnt = 3'($countones(tied));
    case (tie_cnt)
      3'd2:    rank = {1'b0, req_q.tie_pick[0]};
      3'd3:    rank = (req_q.tie_pick == 2'd3) ? 2'd0 : req_q.tie_pick;
      3'd4:    rank = req_q.tie_pick;
      default: rank = '0;
    endcase
    for (int a = 0; a < NUM_MOVES; a++) begin
      if (tied[a]) begin
        if (!found && seen == {1'b0, rank}) begin
          best_m_d = 2'(a);
          found    = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  // Target and blend arithmetic, round-half-up shifts on Q16.16
  logic signed [WideW-1:0]      tgt_sum, mix_sum;
  logic signed [VALUE_BITS-1:0] nv_d;
  logic [CFG_DATA_W-1:0]        keep;

  assign keep    = ONE_Q16 - alpha;
  assign tgt_sum = (WideW'(req_q.reward_in) <<< 16) + ((WideW'(prod_g_q) + Round) >>> 16);
  assign mix_sum = (WideW'(p_old_q) + WideW'(p_tgt_q) + Round) >>> 16;
  assign nv_d    = sat_v(mix_sum);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_q   <= req_i;
          moves_q <= next_moves;
        end
      end
      S_NEXT: begin
        best_q   <= best_d;
        best_m_q <= best_m_d;
      end
      S_CUR: begin
        cur_row_q <= ram_rdata;
        old_q     <= ram_rdata[req_q.move*VALUE_BITS +: VALUE_BITS];
        prod_g_q  <= $signed({1'b0, gamma}) * best_q;
      end
      S_TGT: target_q <= sat_v(tgt_sum);
      S_MIX: begin
        p_old_q <= $signed({1'b0, keep}) * old_q;
        p_tgt_q <= $signed({1'b0, alpha}) * target_q;
      end
      default: ;
    endcase
  end

  // Control
  gqtu_res_t res_q, res_d;
  logic      res_valid_q, res_valid_d;
  logic [AddrW-1:0] clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr(req_q.cur_row, req_q.cur_col);
    ram_raddr   = cell_addr(req_q.cur_row, req_q.cur_col);
    ram_wdata   = cur_row_q;
    ram_wdata[req_q.move*VALUE_BITS +: VALUE_BITS] = nv_d;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Cells - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = cell_addr(req_i.next_row, req_i.next_col);
        if (accept) begin
          if (item_bad) begin
            res_valid_d = 1'b1;
            res_d       = '0;
            res_d.bad_item = 1'b1;
          end else begin
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: state_d = S_CUR;
      S_CUR:  state_d = S_TGT;
      S_TGT:  state_d = S_MIX;
      S_MIX:  state_d = S_WR;
      S_WR: begin
        ram_we           = 1'b1;
        res_valid_d      = 1'b1;
        res_d.new_value  = OUT_W'(nv_d);
        res_d.best_move  = best_m_q;
        res_d.best_value = OUT_W'(best_q);
        res_d.bad_item   = 1'b0;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  a_wr_gives_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |=> res_valid_q && !res_q.bad_item)
    else $error("write-back without result");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> (res_valid_q && res_q.bad_item) || state_q == S_NEXT)
    else $error("accepted request dropped");

  a_good_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.bad_item |-> $past(state_q) == S_WR)
    else $error("good result not from write-back");

endmodule

// ===== rtl/core/gqtu_ram.sv =====
module gqtu_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_grid_q_table_update_top.sv =====
`timescale 1ns / 1ps

module tb_grid_q_table_update_top;
  import gqtu_pkg::*;

  // Random requests after the directed rows; the run stops feeding once this many have gone in
  localparam int RAND_ITEMS = 1925;
  // Margin once the pipe is empty, before a register write or the end
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_GAP = 17;
  localparam int REQ_W = $bits(gqtu_req_t);
  localparam longint VAL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam longint HALF = 32768;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  gqtu_req_t             req_d = '0;
  logic                  res_valid_o;
  gqtu_res_t             res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  grid_q_table_update_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_d),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: well beyond the slowest legal run, clear sweep included
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the block: Q table and the four registers as last written
  // ---------------------------------------------------------------------------
  longint q_mirror [0:1023];
  logic [4:0]  rows_q  = GRID_ROWS_RST;
  logic [4:0]  cols_q  = GRID_COLS_RST;
  logic [16:0] alpha_q = LEARN_RATE_RST;
  logic [16:0] gamma_q = DISCOUNT_RST;

  gqtu_res_t pending_res [$];
  int        mismatches = 0;

  initial begin
    foreach (q_mirror[i]) q_mirror[i] = 0;
  end

  // Register values above the grid maximum act as the maximum
  function automatic int rows_in_use();
    return (rows_q > 16) ? 16 : int'(rows_q);
  endfunction

  function automatic int cols_in_use();
    return (cols_q > 16) ? 16 : int'(cols_q);
  endfunction

  function automatic bit on_grid(int r, int c);
    return (r >= 0) && (c >= 0) && (r < rows_in_use()) && (c < cols_in_use());
  endfunction

  function automatic int row_step(logic [1:0] m);
    case (gqtu_move_e'(m))
      MOVE_ROW_INC: return 1;
      MOVE_ROW_DEC: return -1;
      default:      return 0;
    endcase
  endfunction

  function automatic int col_step(logic [1:0] m);
    case (gqtu_move_e'(m))
      MOVE_COL_INC: return 1;
      MOVE_COL_DEC: return -1;
      default:      return 0;
    endcase
  endfunction

  function automatic int cell_slot(int r, int c, int m);
    return ((r * 16 + c) * 4 + m) % 1024;
  endfunction

  function automatic longint sat_q16(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  // One Q-learning step: greedy max over the reached cell, then the alpha blend.
  // Updates the mirror table and returns the result the block should show.
  function automatic gqtu_res_t q_update(gqtu_req_t r);
    gqtu_res_t o;
    int        cr, cc, nr, nc, a, cnt, rank;
    longint    best, tgt, old, nv, alpha, gamma, v, rw;
    bit        any;
    logic [1:0] bm;
    cr = r.cur_row;
    cc = r.cur_col;
    nr = r.next_row;
    nc = r.next_col;
    o  = '0;
    if (!on_grid(cr, cc) || !on_grid(nr, nc) ||
        !on_grid(cr + row_step(r.move), cc + col_step(r.move))) begin
      o.bad_item = 1'b1;
      return o;
    end
    best = 0;
    any  = 1'b0;
    cnt  = 0;
    bm   = 2'd0;
    for (a = 0; a < 4; a++) begin
      if (on_grid(nr + row_step(a[1:0]), nc + col_step(a[1:0]))) begin
        v = q_mirror[cell_slot(nr, nc, a)];
        if (!any || v > best) best = v;
        any = 1'b1;
      end
    end
    // tie break: scan moves in order, take rank tie_pick mod count
    if (any) begin
      for (a = 0; a < 4; a++)
        if (on_grid(nr + row_step(a[1:0]), nc + col_step(a[1:0])) &&
            q_mirror[cell_slot(nr, nc, a)] == best) cnt++;
      rank = int'(r.tie_pick) % cnt;
      for (a = 0; a < 4; a++) begin
        if (on_grid(nr + row_step(a[1:0]), nc + col_step(a[1:0])) &&
            q_mirror[cell_slot(nr, nc, a)] == best) begin
          if (rank == 0) begin
            bm = a[1:0];
            break;
          end
          rank--;
        end
      end
    end
    alpha = (alpha_q > ONE_Q16) ? 65536 : longint'(alpha_q);
    gamma = (gamma_q > ONE_Q16) ? 65536 : longint'(gamma_q);
    rw    = longint'($signed(r.reward_in));
    // >>> on signed longint is a floor shift
    tgt = sat_q16(rw * 65536 + ((gamma * best + HALF) >>> 16));
    old = q_mirror[cell_slot(cr, cc, r.move)];
    nv  = sat_q16(((65536 - alpha) * old + alpha * tgt + HALF) >>> 16);
    q_mirror[cell_slot(cr, cc, r.move)] = nv;
    o.new_value  = nv[31:0];
    o.best_move  = bm;
    o.best_value = best[31:0];
    o.bad_item   = 1'b0;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is compared with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gqtu_res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_res.size() == 0) begin
        $error("result with no request outstanding: %p", res_o);
        mismatches++;
      end else begin
        want = pending_res.pop_front();
        if (res_o.new_value !== want.new_value) begin
          $error("new_value: expected %0d, got %0d", want.new_value, res_o.new_value);
          mismatches++;
        end
        if (res_o.best_move !== want.best_move) begin
          $error("best_move: expected %0d, got %0d", want.best_move, res_o.best_move);
          mismatches++;
        end
        if (res_o.best_value !== want.best_value) begin
          $error("best_value: expected %0d, got %0d", want.best_value, res_o.best_value);
          mismatches++;
        end
        if (res_o.bad_item !== want.bad_item) begin
          $error("bad_item: expected %0d, got %0d", want.bad_item, res_o.bad_item);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Lower start, let the pipe empty and the last write-back land.
  // Also covers the clear sweep after reset, since busy is high for it.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(gqtu_cfg_e idx, logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_GRID_ROWS:  rows_q  = val[4:0];
      CFG_GRID_COLS:  cols_q  = val[4:0];
      CFG_LEARN_RATE: alpha_q = val;
      CFG_DISCOUNT:   gamma_q = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [16:0] rows, logic [16:0] cols,
                          logic [16:0] alpha, logic [16:0] gamma);
    settle();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_LEARN_RATE, alpha);
    write_reg(CFG_DISCOUNT, gamma);
    cfg_valid_i <= 1'b0;
  endtask

  // Present one request and hold it until taken. start stays high when gap is 0
  // so back-to-back requests never see it drop and rise in one step.
  task automatic issue(gqtu_req_t r, int gap, bit typed, gqtu_res_t typed_res);
    gqtu_res_t pred;
    start <= 1'b1;
    req_d <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = q_update(r);
    if (typed) pred = typed_res;
    pending_res = {pending_res, pred};
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic gqtu_req_t mk_req(int cr, int cc, gqtu_move_e mv, int rw,
                                       int nr, int nc, int pick);
    gqtu_req_t r;
    r.cur_row   = cr[3:0];
    r.cur_col   = cc[3:0];
    r.move      = mv;
    r.reward_in = rw[15:0];
    r.next_row  = nr[3:0];
    r.next_col  = nc[3:0];
    r.tie_pick  = pick[1:0];
    return r;
  endfunction

  // Rewards: rails, small values that keep ties alive, and anything else
  function automatic logic [15:0] pick_reward();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom_range(0, 16) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly legal transitions inside the current grid; some broken, some pure noise
  function automatic gqtu_req_t rand_req();
    gqtu_req_t r;
    int         er, ec, cr, cc, n, k, roll;
    logic [1:0] legal [$];
    r    = gqtu_req_t'(REQ_W'({$urandom, $urandom}));
    r.reward_in = pick_reward();
    er   = rows_in_use();
    ec   = cols_in_use();
    roll = $urandom_range(0, 99);
    if (er == 0 || ec == 0 || roll < 8) return r;
    cr = $urandom_range(0, er - 1);
    cc = $urandom_range(0, ec - 1);
    for (k = 0; k < 4; k++)
      if (on_grid(cr + row_step(k[1:0]), cc + col_step(k[1:0]))) legal = {legal, k[1:0]};
    r.cur_row = cr[3:0];
    r.cur_col = cc[3:0];
    if (legal.size() == 0 || roll < 14) return r;  // move most likely leaves the grid
    r.move = legal[$urandom_range(0, legal.size() - 1)];
    if (roll < 85) begin
      n = cr + row_step(r.move);
      r.next_row = n[3:0];
      n = cc + col_step(r.move);
      r.next_col = n[3:0];
    end else begin
      // any cell on the grid counts as reached
      r.next_row = 4'($urandom_range(0, er - 1));
      r.next_col = 4'($urandom_range(0, ec - 1));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan: register settings and requests, with hand-typed results
  // where they are obvious (table fresh from reset, rejected requests)
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    logic [16:0] rows, cols, alpha, gamma;
    gqtu_req_t   req;
    bit          typed;
    gqtu_res_t   res;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void plan_cfg(logic [16:0] rows, logic [16:0] cols,
                                   logic [16:0] alpha, logic [16:0] gamma);
    plan_row_t p;
    p        = '{default: '0};
    p.is_cfg = 1'b1;
    p.rows   = rows;
    p.cols   = cols;
    p.alpha  = alpha;
    p.gamma  = gamma;
    plan = {plan, p};
  endfunction

  function automatic void plan_req(gqtu_req_t r, bit typed, gqtu_res_t res);
    plan_row_t p;
    p       = '{default: '0};
    p.req   = r;
    p.typed = typed;
    p.res   = res;
    plan = {plan, p};
  endfunction

  initial begin
    gqtu_res_t zero_res, bad_res, none;
    int        sent, phase_len, k, gap;
    bit        idle_on;
    logic [16:0] rv, cv, av, gv;

    zero_res = '0;
    none     = '0;
    bad_res  = '0;
    bad_res.bad_item = 1'b1;

    // Reset grid 4x12: untouched table gives all zeros
    plan_req(mk_req(0, 0, MOVE_ROW_INC, 0, 1, 0, 0), 1'b1, zero_res);
    plan_req(mk_req(0, 0, MOVE_COL_INC, 32767, 0, 1, 3), 1'b0, none);
    plan_req(mk_req(3, 11, MOVE_ROW_DEC, -32768, 2, 11, 2), 1'b0, none);
    plan_req(mk_req(3, 11, MOVE_COL_DEC, -1, 3, 10, 1), 1'b0, none);
    // moves off each edge, cells outside the grid
    plan_req(mk_req(0, 0, MOVE_ROW_DEC, 5, 0, 0, 0), 1'b1, bad_res);
    plan_req(mk_req(0, 0, MOVE_COL_DEC, 5, 0, 0, 0), 1'b1, bad_res);
    plan_req(mk_req(3, 11, MOVE_ROW_INC, 5, 3, 11, 0), 1'b1, bad_res);
    plan_req(mk_req(3, 11, MOVE_COL_INC, 5, 3, 11, 0), 1'b1, bad_res);
    plan_req(mk_req(4, 0, MOVE_COL_INC, 5, 0, 1, 0), 1'b1, bad_res);
    plan_req(mk_req(0, 12, MOVE_ROW_INC, 5, 1, 0, 0), 1'b1, bad_res);
    plan_req(mk_req(1, 1, MOVE_ROW_INC, 5, 15, 15, 0), 1'b1, bad_res);
    // Full 16x16, alpha = gamma = 1.0: drive both saturation rails
    plan_cfg(17'd16, 17'd16, ONE_Q16, ONE_Q16);
    plan_req(mk_req(0, 0, MOVE_COL_INC, 32767, 0, 1, 0), 1'b0, none);
    plan_req(mk_req(0, 1, MOVE_COL_DEC, 32767, 0, 0, 0), 1'b0, none);
    plan_req(mk_req(15, 15, MOVE_ROW_DEC, -32768, 14, 15, 0), 1'b0, none);
    plan_req(mk_req(15, 15, MOVE_COL_DEC, -32768, 15, 14, 0), 1'b0, none);
    plan_req(mk_req(14, 15, MOVE_ROW_INC, -32768, 15, 15, 3), 1'b0, none);
    // four-way tie in open field, top rank picked
    plan_req(mk_req(5, 5, MOVE_ROW_INC, 0, 6, 6, 3), 1'b0, none);
    // Single row, alpha above unity, gamma 0
    plan_cfg(17'd1, 17'd16, 17'h1FFFF, 17'd0);
    plan_req(mk_req(0, 0, MOVE_COL_INC, 100, 0, 1, 1), 1'b0, none);
    plan_req(mk_req(0, 5, MOVE_ROW_INC, 100, 0, 5, 1), 1'b1, bad_res);
    // Oversized dimensions clamp to 16; alpha 0 leaves the entry alone
    plan_cfg(17'd31, 17'd31, 17'd0, 17'h1FFFF);
    plan_req(mk_req(15, 15, MOVE_ROW_DEC, 5, 14, 15, 2), 1'b0, none);
    // Empty grid rejects everything
    plan_cfg(17'd0, 17'd0, LEARN_RATE_RST, DISCOUNT_RST);
    plan_req(mk_req(0, 0, MOVE_COL_INC, 1, 0, 1, 0), 1'b1, bad_res);
    // 1x1: no move stays inside
    plan_cfg(17'd1, 17'd1, LEARN_RATE_RST, DISCOUNT_RST);
    plan_req(mk_req(0, 0, MOVE_ROW_INC, 1, 0, 0, 0), 1'b1, bad_res);
    // 2x1: reached cell has a single legal move
    plan_cfg(17'd2, 17'd1, LEARN_RATE_RST, DISCOUNT_RST);
    plan_req(mk_req(0, 0, MOVE_ROW_INC, 7, 1, 0, 3), 1'b0, none);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();  // clear sweep

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_grid(plan[i].rows, plan[i].cols, plan[i].alpha, plan[i].gamma);
      end else begin
        issue(plan[i].req, $urandom_range(0, MAX_GAP), plan[i].typed, plan[i].res);
      end
    end

    // Random phases, each under a fresh register setting
    sent = 0;
    while (sent < RAND_ITEMS) begin
      // small grids revisit entries often, so the table fills with history
      case ($urandom_range(0, 9))
        0:       rv = 17'd0;
        1:       rv = 17'($urandom_range(17, 31));
        2, 3:    rv = 17'd16;
        default: rv = 17'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 9))
        0:       cv = 17'($urandom_range(17, 31));
        1, 2:    cv = 17'd16;
        3:       cv = 17'd1;
        default: cv = 17'($urandom_range(1, 6));
      endcase
      // bits above the 5-bit field are don't-care
      rv[16:5] = 12'($urandom);
      cv[16:5] = 12'($urandom);
      case ($urandom_range(0, 5))
        0:       av = 17'd0;
        1:       av = ONE_Q16;
        2:       av = 17'($urandom_range(65537, 131071));
        default: av = 17'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 5))
        0:       gv = 17'd0;
        1:       gv = ONE_Q16;
        2:       gv = 17'($urandom_range(65537, 131071));
        default: gv = 17'($urandom_range(0, 65536));
      endcase
      set_grid(rv, cv, av, gv);

      phase_len = $urandom_range(80, 220);
      idle_on   = $urandom_range(0, 1);
      for (k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
        if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        issue(rand_req(), gap, 1'b0, none);
        sent++;
        // now and then hold off until the pipe is empty
        if ($urandom_range(0, 63) == 0) settle();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gqtu_pkg.sv
rtl/core/gqtu_ram.sv
rtl/core/grid_q_table_update_top.sv
tb/tb_grid_q_table_update_top.sv
